// ===== src/ltlb_pkg.sv =====
// Package: shared types and constants for the LRU TLB.
package ltlb_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PID_BITS    = 16;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_BITS  = 20;
    localparam int IDX_BITS    = $clog2(TLB_ENTRIES);
    localparam int CNT_BITS    = $clog2(TLB_ENTRIES + 1);
    localparam int CFG_BITS    = 5;
    localparam int POS_BITS    = 5;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_RM_KEY = 2'd2,
        REQ_RM_POS = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // classified request handed from front to back
    typedef struct packed {
        req_t                  req;
        logic [PID_BITS-1:0]   pid;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic [POS_BITS-1:0]   pos;
        logic                  range_err;
    } cmd_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
        logic [PID_BITS-1:0]   removed_pid;
        logic [PAGE_BITS-1:0]  removed_page;
        status_t               status;
        logic                  full_res;
        logic [4:0]            occupancy;
    } res_t;

endpackage

// ===== src/ltlb_front.sv =====
// Front end: accepts requests, checks position range, queues commands.
module ltlb_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [ltlb_pkg::PID_BITS-1:0]   process_id,
    input  logic [ltlb_pkg::PAGE_BITS-1:0]  page,
    input  logic [ltlb_pkg::FRAME_BITS-1:0] frame,
    input  logic [ltlb_pkg::POS_BITS-1:0]   position,
    input  logic [ltlb_pkg::CFG_BITS-1:0]   cap,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output ltlb_pkg::cmd_t                 cmd
);
    import ltlb_pkg::*;

    cmd_t q_reg [QDEPTH];
    logic wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t c;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'(QDEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        c.req       = req_t'(req_type);
        c.pid       = process_id;
        c.page      = page;
        c.frame     = frame;
        c.pos       = position;
        c.range_err = (position >= cap);
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== src/ltlb_back.sv =====
// Back end: recency list storage, search, shift and result register.
module ltlb_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  ltlb_pkg::cmd_t               cmd,
    input  logic                         cfg_valid,
    input  logic [ltlb_pkg::CFG_BITS-1:0] cfg_data,
    output logic [ltlb_pkg::CFG_BITS-1:0] cap,
    output logic                         res_valid,
    input  logic                         res_ready,
    output ltlb_pkg::res_t               res
);
    import ltlb_pkg::*;

    logic [PID_BITS-1:0]   pid_reg   [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]  page_reg  [TLB_ENTRIES];
    logic [FRAME_BITS-1:0] frame_reg [TLB_ENTRIES];
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CFG_BITS-1:0]   cap_reg;
    logic                  busy_reg, busy_next;
    logic                  found_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic                  res_valid_reg;
    res_t                  res_reg, res_next;

    logic [TLB_ENTRIES-1:0] match;
    logic                   found;
    logic [IDX_BITS-1:0]    fidx;
    logic [CNT_BITS-1:0]    capn, cnt0, ipos;
    logic                   del_en, ins_en;
    logic [IDX_BITS-1:0]    del_idx;
    logic [PID_BITS-1:0]    ins_pid;
    logic [PAGE_BITS-1:0]   ins_page;
    logic [FRAME_BITS-1:0]  ins_frame;
    logic [CFG_BITS-1:0]    cap_w;

    assign cap       = cap_reg;
    assign capn      = CNT_BITS'(cap_reg);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    // head of queue stays put through search and update; popped as the update lands
    assign cmd_ready = busy_reg && (!res_valid_reg || res_ready);

    // search step: parallel key compare, priority to front
    always_comb
    begin
        found = 1'b0;
        fidx  = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match[i] = (CNT_BITS'(i) < count_reg) && pid_reg[i] == cmd.pid
                       && page_reg[i] == cmd.page;
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found = 1'b1;
                fidx  = IDX_BITS'(i);
            end
        end
    end

    // update step: work out delete/insert and the result
    always_comb
    begin
        del_en    = 1'b0;
        ins_en    = 1'b0;
        del_idx   = idx_reg;
        ins_pid   = cmd.pid;
        ins_page  = cmd.page;
        ins_frame = cmd.frame;
        ipos      = '0;
        cnt0      = count_reg;
        res_next  = '0;
        res_next.status = ST_OK;
        unique case (cmd.req)
            REQ_LOOKUP:
            begin
                if (found_reg)
                begin
                    del_en = 1'b1;
                    ins_en = 1'b1;
                    ins_frame = frame_reg[idx_reg];
                    res_next.hit = 1'b1;
                    res_next.frame_out = frame_reg[idx_reg];
                end
                else
                begin
                    res_next.status = ST_MISS;
                end
            end
            REQ_INSERT:
            begin
                if (cmd.range_err)
                begin
                    res_next.status = ST_RANGE;
                end
                else
                begin
                    ins_en = 1'b1;
                    if (count_reg >= capn)
                    begin
                        cnt0 = capn - 1'b1;
                    end
                    ipos = (CNT_BITS'(cmd.pos) > cnt0) ? cnt0 : CNT_BITS'(cmd.pos);
                end
            end
            default:
            begin
                if (cmd.req == REQ_RM_POS)
                begin
                    del_idx = cmd.pos[IDX_BITS-1:0];
                end
                if (cmd.req == REQ_RM_POS && cmd.range_err)
                begin
                    res_next.status = ST_RANGE;
                end
                else if ((cmd.req == REQ_RM_KEY && !found_reg)
                         || (cmd.req == REQ_RM_POS && CNT_BITS'(cmd.pos) >= count_reg))
                begin
                    res_next.status = ST_MISS;
                end
                else
                begin
                    del_en = 1'b1;
                    res_next.hit          = 1'b1;
                    res_next.frame_out    = frame_reg[del_idx];
                    res_next.removed_pid  = pid_reg[del_idx];
                    res_next.removed_page = page_reg[del_idx];
                end
            end
        endcase
        count_next = cnt0 - CNT_BITS'(del_en) + CNT_BITS'(ins_en);
        res_next.occupancy = 5'(count_next);
        res_next.full_res  = (count_next == capn);
    end

    assign busy_next = busy_reg ? !(res_valid_reg == 1'b0 || res_ready)
                                : cmd_valid;
    assign cap_w = (cfg_data == CFG_BITS'(0)) ? CFG_BITS'(1)
                 : (cfg_data > CFG_BITS'(TLB_ENTRIES)) ? CFG_BITS'(TLB_ENTRIES) : cfg_data;

    // shift array: delete closes the gap, insert opens one at ipos
    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            found_reg <= found;
            idx_reg   <= fidx;
        end
        if (busy_reg && (!res_valid_reg || res_ready))
        begin
            res_reg <= res_next;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                logic [PID_BITS-1:0]   p1;
                logic [PAGE_BITS-1:0]  g1;
                logic [FRAME_BITS-1:0] f1;
                p1 = pid_reg[i];
                g1 = page_reg[i];
                f1 = frame_reg[i];
                if (del_en && IDX_BITS'(i) >= del_idx && i < TLB_ENTRIES - 1)
                begin
                    p1 = pid_reg[i+1];
                    g1 = page_reg[i+1];
                    f1 = frame_reg[i+1];
                end
                if (ins_en)
                begin
                    if (CNT_BITS'(i) == ipos)
                    begin
                        p1 = ins_pid;
                        g1 = ins_page;
                        f1 = ins_frame;
                    end
                    else if (CNT_BITS'(i) > ipos && i > 0)
                    begin
                        // lookup never deletes beyond idx, so i-1 untouched by delete there
                        if (del_en && IDX_BITS'(i) > del_idx)
                        begin
                            p1 = pid_reg[i];
                            g1 = page_reg[i];
                            f1 = frame_reg[i];
                        end
                        else
                        begin
                            p1 = pid_reg[i-1];
                            g1 = page_reg[i-1];
                            f1 = frame_reg[i-1];
                        end
                    end
                end
                pid_reg[i]   <= p1;
                page_reg[i]  <= g1;
                frame_reg[i] <= f1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CFG_BITS'(TLB_ENTRIES);
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (busy_reg && (!res_valid_reg || res_ready))
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                cap_reg <= cap_w;
                if (count_reg > CNT_BITS'(cap_w))
                begin
                    count_reg <= CNT_BITS'(cap_w);
                end
            end
        end
    end
endmodule

// ===== src/lru_tlb.sv =====
// Top level: LRU TLB with queued front end and list back end.
// A taken request waits in the queue, then the back end searches, then updates and registers the result.
// The back end takes the next request only after the update lands; it stalls while a result is not taken.
// A two-entry queue lets requests be taken while the back end is busy.
// Reset (rst_n, async, active low): empty list, capacity 16, no results pending.
module lru_tlb (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // req_type, process_id, page, frame, position, zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // hit, frame_out, removed_pid, removed_page, status,
                                    // full_res, occupancy, zero pad
);
    import ltlb_pkg::*;

    cmd_t                cmd;
    res_t                res;
    logic                cmd_valid, cmd_ready;
    logic [CFG_BITS-1:0] cap;

    assign cfg_ready = 1'b1;

    ltlb_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .req_type(s_tdata[1:0]), .process_id(s_tdata[17:2]),
        .page(s_tdata[37:18]), .frame(s_tdata[57:38]), .position(s_tdata[62:58]),
        .cap(cap), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ltlb_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cap(cap),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {7'd0, res.occupancy, res.full_res, res.status, res.removed_page,
                      res.removed_pid, res.frame_out, res.hit};
endmodule

// ===== src/ltlb_checker.sv =====
// Checker: port-level properties of the LRU TLB, bound to the top level.
module ltlb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[64:60] <= 5'd16)
        else $error("occupancy beyond table size");
    a_hitok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[58:57] == 2'd0)
        else $error("hit with error status");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[58:57] != 2'd0 |-> m_tdata[56:1] == '0)
        else $error("failed request carries data");
endmodule

bind lru_tlb ltlb_checker u_chk (.*);
